// File: hdl/bounded_linked_list_with_free_pool_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linked list block
// Implication checks on clk and arst_n. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LINKED_LIST_WITH_FREE_POOL_ASSERT_SVH
`define BOUNDED_LINKED_LIST_WITH_FREE_POOL_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BLL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define BLL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BLL_ASSERT_IMP(lbl, ante, cons, msg)
`define BLL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/bll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bll_pkg
// Sizes, codes and control types shared by the linked list block.
// ----------------------------------------------------------------------------
package bll_pkg;

	localparam int POOL_DEPTH = 16;
	localparam int VALUE_W    = 32;
	localparam int PTR_W      = $clog2(POOL_DEPTH);
	localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
	localparam int OP_W       = 3;
	localparam int POS_W      = 5;
	localparam int ST_W       = 2;
	// position arithmetic width: room for count + 1 and position
	localparam int P_W        = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

	typedef enum logic [OP_W-1:0] {
		OP_INS_HEAD,
		OP_INS_TAIL,
		OP_INS_POS,
		OP_DEL_HEAD,
		OP_DEL_TAIL,
		OP_DEL_POS
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK,
		ST_OVER,
		ST_UNDER,
		ST_BADPOS
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_WALK,
		S_INS_HEAD,
		S_INS_TAKE,
		S_INS_SPLICE,
		S_INS_LINK,
		S_DEL_HEAD,
		S_DEL_FIND,
		S_DEL_SPLICE,
		S_DEL_FREE,
		S_LOAD_HEAD,
		S_LOAD_TAIL,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LATCH,
		CMD_CHECK,
		CMD_STEP,
		CMD_INS_HEAD,
		CMD_INS_TAKE,
		CMD_INS_SPLICE,
		CMD_INS_LINK,
		CMD_DEL_HEAD,
		CMD_DEL_FIND,
		CMD_DEL_SPLICE,
		CMD_DEL_FREE,
		CMD_LOAD_HEAD,
		CMD_LOAD_TAIL,
		CMD_RESPOND
	} cmd_t;

	typedef struct packed {
		logic err;          // request flagged, state untouched
		logic ins;          // insert family
		logic at_head;      // no walk needed
		logic walk_done;    // step counter exhausted
		logic victim_tail;  // node being removed is the tail
		logic rsp_free;     // output register can take a word
	} sts_t;

endpackage

// File: hdl/bll_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bll_req_if
// Request channel: valid/ready with operation, position and value.
// ----------------------------------------------------------------------------
interface bll_req_if;
	logic                                valid;
	logic                                ready;
	logic [bll_pkg::OP_W-1:0]            operation;
	logic [bll_pkg::POS_W-1:0]           position;
	logic signed [bll_pkg::VALUE_W-1:0]  value;

	modport source (output valid, output operation, output position, output value,
		input ready);
	modport sink (input valid, input operation, input position, input value,
		output ready);
endinterface

// File: hdl/bll_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bll_rsp_if
// Response channel: valid/ready with status, count and end values.
// ----------------------------------------------------------------------------
interface bll_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [bll_pkg::ST_W-1:0]            status;
	logic [bll_pkg::CNT_W-1:0]           count;
	logic signed [bll_pkg::VALUE_W-1:0]  head_value;
	logic signed [bll_pkg::VALUE_W-1:0]  tail_value;
	logic                                list_empty;

	modport source (output valid, output status, output count, output head_value,
		output tail_value, output list_empty, input ready);
	modport sink (input valid, input status, input count, input head_value,
		input tail_value, input list_empty, output ready);
endinterface

// File: hdl/bll_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bll_ctrl
// Sequencer: steps one request through check, walk, relink and response.
// ----------------------------------------------------------------------------
module bll_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bll_pkg::sts_t sts,
	output bll_pkg::cmd_t cmd
);
	import bll_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (sts.err)          state_d = S_DONE;
				else if (!sts.at_head) state_d = S_WALK;
				else if (sts.ins)      state_d = S_INS_HEAD;
				else                   state_d = S_DEL_HEAD;
			end
			S_WALK: begin
				if (sts.walk_done) state_d = sts.ins ? S_INS_TAKE : S_DEL_FIND;
			end
			S_INS_HEAD:   state_d = S_DONE;
			S_INS_TAKE:   state_d = S_INS_SPLICE;
			S_INS_SPLICE: state_d = S_INS_LINK;
			S_INS_LINK:   state_d = S_DONE;
			S_DEL_HEAD:   state_d = S_LOAD_HEAD;
			S_DEL_FIND:   state_d = S_DEL_SPLICE;
			S_DEL_SPLICE: state_d = S_DEL_FREE;
			S_DEL_FREE: begin
				state_d = sts.victim_tail ? S_LOAD_TAIL : S_DONE;
			end
			S_LOAD_HEAD:  state_d = S_DONE;
			S_LOAD_TAIL:  state_d = S_DONE;
			S_DONE: begin
				if (sts.rsp_free) state_d = S_IDLE;
			end
			default:      state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = CMD_NONE;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) cmd = CMD_LATCH;
			end
			S_CHECK:      cmd = CMD_CHECK;
			S_WALK:       cmd = sts.walk_done ? CMD_NONE : CMD_STEP;
			S_INS_HEAD:   cmd = CMD_INS_HEAD;
			S_INS_TAKE:   cmd = CMD_INS_TAKE;
			S_INS_SPLICE: cmd = CMD_INS_SPLICE;
			S_INS_LINK:   cmd = CMD_INS_LINK;
			S_DEL_HEAD:   cmd = CMD_DEL_HEAD;
			S_DEL_FIND:   cmd = CMD_DEL_FIND;
			S_DEL_SPLICE: cmd = CMD_DEL_SPLICE;
			S_DEL_FREE:   cmd = CMD_DEL_FREE;
			S_LOAD_HEAD:  cmd = CMD_LOAD_HEAD;
			S_LOAD_TAIL:  cmd = CMD_LOAD_TAIL;
			S_DONE:       cmd = sts.rsp_free ? CMD_RESPOND : CMD_NONE;
			default:      cmd = CMD_NONE;
		endcase
	end

endmodule

// File: hdl/bll_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bll_dpath
// Node pool, link table, list pointers, request check and output register.
// ----------------------------------------------------------------------------
module bll_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bll_pkg::cmd_t                       cmd,
	output bll_pkg::sts_t                       sts,
	input  logic [bll_pkg::OP_W-1:0]            req_operation,
	input  logic [bll_pkg::POS_W-1:0]           req_position,
	input  logic signed [bll_pkg::VALUE_W-1:0]  req_value,
	input  logic                                cfg_we,
	input  logic [bll_pkg::CNT_W-1:0]           cfg_wdata,
	input  logic                                rsp_ready,
	output logic                                rsp_valid,
	output logic [bll_pkg::ST_W-1:0]            rsp_status,
	output logic [bll_pkg::CNT_W-1:0]           rsp_count,
	output logic signed [bll_pkg::VALUE_W-1:0]  rsp_head_value,
	output logic signed [bll_pkg::VALUE_W-1:0]  rsp_tail_value,
	output logic                                rsp_list_empty
);
	import bll_pkg::*;

	// list state
	logic [PTR_W-1:0]          links_q [POOL_DEPTH];
	logic [VALUE_W-1:0]        node_mem [POOL_DEPTH];
	logic [PTR_W-1:0]          head_q, tail_q, free_q;
	logic [CNT_W-1:0]          count_q, cap_q;
	logic signed [VALUE_W-1:0] head_val_q, tail_val_q;

	// request in flight
	logic [OP_W-1:0]           op_q;
	logic [POS_W-1:0]          pos_q;
	logic signed [VALUE_W-1:0] val_q;
	status_t                   st_q;
	logic [PTR_W-1:0]          cur_q, steps_q, new_q, victim_q;
	logic [VALUE_W-1:0]        rd_q;

	// output register
	logic                      rsp_valid_q;
	logic [ST_W-1:0]           rsp_status_q;
	logic [CNT_W-1:0]          rsp_count_q;
	logic signed [VALUE_W-1:0] rsp_head_q, rsp_tail_q;
	logic                      rsp_empty_q;

	logic [PTR_W-1:0] lnk_raddr, lnk_rdata, lnk_waddr, lnk_wdata, mem_raddr;
	logic             lnk_we, mem_we;
	logic [CNT_W-1:0] cap_eff;
	logic [P_W-1:0]   cnt_x, pos_x, req_p, walk_x;
	status_t          chk_st;
	logic             is_ins, at_head, rsp_free;

	// ---------------- request check ----------------
	assign cap_eff = (cap_q > CNT_W'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH) : cap_q;
	assign cnt_x   = P_W'(count_q);
	assign pos_x   = P_W'(pos_q);

	always_comb begin
		req_p   = '0;
		chk_st  = ST_BADPOS;
		is_ins  = 1'b0;
		at_head = 1'b0;
		unique case (op_q) inside
			OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
				is_ins = 1'b1;
				if (op_q == OP_INS_HEAD)      req_p = P_W'(1);
				else if (op_q == OP_INS_TAIL) req_p = cnt_x + P_W'(1);
				else                          req_p = pos_x;
				if (count_q >= cap_eff)
					chk_st = ST_OVER;
				else if (req_p == '0 || req_p > cnt_x + P_W'(1))
					chk_st = ST_BADPOS;
				else
					chk_st = ST_OK;
				at_head = (count_q == '0) || (req_p == P_W'(1));
			end
			OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
				if (op_q == OP_DEL_HEAD)      req_p = P_W'(1);
				else if (op_q == OP_DEL_TAIL) req_p = cnt_x;
				else                          req_p = pos_x;
				if (count_q == '0)
					chk_st = ST_UNDER;
				else if (req_p == '0 || req_p > cnt_x)
					chk_st = ST_BADPOS;
				else
					chk_st = ST_OK;
				at_head = (req_p == P_W'(1));
			end
			default: chk_st = ST_BADPOS;
		endcase
	end

	// steps from head to predecessor of position p
	assign walk_x = req_p - P_W'(2);

	assign rsp_free = !rsp_valid_q || rsp_ready;

	assign sts.err         = (chk_st != ST_OK);
	assign sts.ins         = is_ins;
	assign sts.at_head     = at_head;
	assign sts.walk_done   = (steps_q == '0);
	assign sts.victim_tail = (victim_q == tail_q);
	assign sts.rsp_free    = rsp_free;

	// ---------------- link table port ----------------
	assign lnk_rdata = links_q[lnk_raddr];

	always_comb begin
		lnk_raddr = cur_q;
		lnk_we    = 1'b0;
		lnk_waddr = cur_q;
		lnk_wdata = free_q;
		mem_we    = 1'b0;
		mem_raddr = cur_q;
		case (cmd)
			CMD_INS_HEAD: begin
				lnk_raddr = free_q;
				lnk_we    = 1'b1;
				lnk_waddr = free_q;
				lnk_wdata = (count_q == '0) ? '0 : head_q;
				mem_we    = 1'b1;
			end
			CMD_INS_TAKE: begin
				lnk_raddr = free_q;
				mem_we    = 1'b1;
			end
			CMD_INS_SPLICE: begin
				lnk_we    = 1'b1;
				lnk_waddr = new_q;
				lnk_wdata = lnk_rdata;
			end
			CMD_INS_LINK: begin
				lnk_we    = 1'b1;
				lnk_wdata = new_q;
			end
			CMD_DEL_HEAD: begin
				lnk_raddr = head_q;
				lnk_we    = 1'b1;
				lnk_waddr = head_q;
				mem_raddr = lnk_rdata;   // value of the new head
			end
			CMD_DEL_SPLICE: begin
				lnk_raddr = victim_q;
				lnk_we    = 1'b1;
				lnk_wdata = lnk_rdata;
			end
			CMD_DEL_FREE: begin
				lnk_we    = 1'b1;
				lnk_waddr = victim_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POOL_DEPTH; i++)
				links_q[i] <= PTR_W'((i + 1) % POOL_DEPTH);
		end else if (lnk_we) begin
			links_q[lnk_waddr] <= lnk_wdata;
		end
	end

	// node values: one write port at the free head, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) node_mem[free_q] <= val_q;
		rd_q <= node_mem[mem_raddr];
	end

	// ---------------- list pointers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			free_q  <= '0;
			count_q <= '0;
			cap_q   <= CNT_W'(POOL_DEPTH);
			st_q    <= ST_OK;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			case (cmd)
				CMD_CHECK: st_q <= chk_st;
				CMD_INS_HEAD: begin
					free_q  <= lnk_rdata;
					head_q  <= free_q;
					if (count_q == '0) tail_q <= free_q;
					count_q <= count_q + CNT_W'(1);
				end
				CMD_INS_TAKE: free_q <= lnk_rdata;
				CMD_INS_LINK: begin
					if (cur_q == tail_q) tail_q <= new_q;
					count_q <= count_q + CNT_W'(1);
				end
				CMD_DEL_HEAD: begin
					free_q  <= head_q;
					count_q <= count_q - CNT_W'(1);
					if (count_q == CNT_W'(1)) begin
						head_q <= '0;
						tail_q <= '0;
					end else begin
						head_q <= lnk_rdata;
					end
				end
				CMD_DEL_FREE: begin
					free_q  <= victim_q;
					count_q <= count_q - CNT_W'(1);
					if (victim_q == tail_q) tail_q <= cur_q;
				end
				default: ;
			endcase
		end
	end

	// ---------------- request payload and walk ----------------
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LATCH: begin
				op_q  <= req_operation;
				pos_q <= req_position;
				val_q <= req_value;
			end
			CMD_CHECK: begin
				cur_q   <= head_q;
				steps_q <= walk_x[PTR_W-1:0];
			end
			CMD_STEP: begin
				cur_q   <= lnk_rdata;
				steps_q <= steps_q - PTR_W'(1);
			end
			CMD_INS_HEAD: begin
				head_val_q <= val_q;
				if (count_q == '0) tail_val_q <= val_q;
			end
			CMD_INS_TAKE: new_q <= free_q;
			CMD_INS_LINK: begin
				if (cur_q == tail_q) tail_val_q <= val_q;
			end
			CMD_DEL_FIND:  victim_q   <= lnk_rdata;
			CMD_LOAD_HEAD: head_val_q <= rd_q;
			CMD_LOAD_TAIL: tail_val_q <= rd_q;
			default: ;
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd == CMD_RESPOND) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_RESPOND) begin
			rsp_status_q <= st_q;
			rsp_count_q  <= count_q;
			rsp_head_q   <= (count_q != '0) ? head_val_q : '0;
			rsp_tail_q   <= (count_q != '0) ? tail_val_q : '0;
			rsp_empty_q  <= (count_q == '0);
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign rsp_status     = rsp_status_q;
	assign rsp_count      = rsp_count_q;
	assign rsp_head_value = rsp_head_q;
	assign rsp_tail_value = rsp_tail_q;
	assign rsp_list_empty = rsp_empty_q;

endmodule

// File: hdl/bounded_linked_list_with_free_pool.sv
`timescale 1ns / 1ps
// Bounded singly linked list in a pool of 16 nodes with a free chain.
// req carries one word per request: operation (insert head/tail/position,
//   delete head/tail/position), a 1-based position and a 32-bit value.
// rsp returns one word per request: status (ok, overflow, underflow, bad
//   position), element count, head and tail values (zero when empty) and an
//   empty flag. A flagged request leaves the list untouched.
// cfg_we/cfg_wdata write the capacity; values above 16 act as 16. Write it
//   only while no request is in flight.
// Timing: one request at a time. A flagged request goes from the check
//   straight to the response, a head insert relinks the free head node
//   directly and a head delete relinks, then loads the new head value.
//   Position and tail operations follow links from the head one node per
//   cycle through the single link-table read port, then splice; a delete
//   that removes the tail then also loads the new tail value. A new
//   request is taken the cycle after the response is registered.
// Reset: empty list, every node chained into the free pool, capacity 16.
// A stalled rsp holds its word; one more request can be worked while it
//   waits, the next result then waits for the output register to drain.
// ----------------------------------------------------------------------------
// bounded_linked_list_with_free_pool
// Top level: sequencer plus list datapath.
// ----------------------------------------------------------------------------
`include "bounded_linked_list_with_free_pool_assert.svh"

module bounded_linked_list_with_free_pool (
	input  logic                      clk,
	input  logic                      arst_n,
	bll_req_if.sink                   req,
	bll_rsp_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic [bll_pkg::CNT_W-1:0] cfg_wdata
);
	import bll_pkg::*;

	cmd_t cmd;    // at most one datapath operation per cycle
	sts_t sts;    // check result and walk/compare flags

	// Controller: owns req.ready, sequences every request.
	bll_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: link table, node values, pointers and the response register.
	bll_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_operation  (req.operation),
		.req_position   (req.position),
		.req_value      (req.value),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.rsp_ready      (rsp.ready),
		.rsp_valid      (rsp.valid),
		.rsp_status     (rsp.status),
		.rsp_count      (rsp.count),
		.rsp_head_value (rsp.head_value),
		.rsp_tail_value (rsp.tail_value),
		.rsp_list_empty (rsp.list_empty)
	);

	// only one request in flight
	`BLL_ASSERT_NXT(a_single_request, req.valid && req.ready, !req.ready, "second request taken")
	// the response register is never overwritten while it still holds a word
	`BLL_ASSERT_IMP(a_no_overwrite, cmd == CMD_RESPOND, sts.rsp_free, "response overwritten")
	// a finished request always shows up on rsp
	`BLL_ASSERT_NXT(a_respond_valid, cmd == CMD_RESPOND, rsp.valid, "response lost")

endmodule
